// ----- rtl/rgbconv_pkg.sv -----
// Shared constants, register indexes and types for the RGB convolution block.
package rgbconv_pkg;

    // default geometry limits
    localparam int DefMaxWidth  = 2048;
    localparam int DefMaxHeight = 2048;
    localparam int DefMaxKernel = 5;

    // fixed field widths
    localparam int PixW   = 24;
    localparam int DimW   = 12;
    localparam int ScaleW = 16;
    localparam int CoefW  = 200;
    localparam int AccW   = 22;   // 25 taps * 255 * 128 fits with margin
    localparam int ProdW  = AccW + ScaleW + 1;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CfgRadius  = 3'd0;
    localparam t_cfg_idx CfgWidth   = 3'd1;
    localparam t_cfg_idx CfgHeight  = 3'd2;
    localparam t_cfg_idx CfgCoeffA  = 3'd3;
    localparam t_cfg_idx CfgCoeffB  = 3'd4;
    localparam t_cfg_idx CfgCoeffC  = 3'd5;
    localparam t_cfg_idx CfgCoeffL  = 3'd6;
    localparam t_cfg_idx CfgScale   = 3'd7;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;    // zero the channel sums
        logic acc;    // add one pixel times tap
        logic scale;  // multiply sums by the scale factor
    } t_mac_ctl;

endpackage

// ----- rtl/rgbconv_linemem.sv -----
// Single-port line store memory with registered read data.
module rgbconv_linemem #(
    parameter int DEPTH = 20480,
    parameter int AW    = 15
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic [rgbconv_pkg::PixW-1:0]  i_wdata,
    output logic [rgbconv_pkg::PixW-1:0]  o_rdata
);
    import rgbconv_pkg::*;

    logic [PixW-1:0] mem [DEPTH];
    logic [PixW-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rgbconv_mac.sv -----
// Per-channel multiply-accumulate, scaling, rounding and clamping.
module rgbconv_mac (
    input  logic                            i_clk,
    input  rgbconv_pkg::t_mac_ctl           i_ctl,
    input  logic [rgbconv_pkg::PixW-1:0]    i_pix,
    input  logic signed [7:0]               i_tap,
    input  logic [rgbconv_pkg::ScaleW-1:0]  i_scale,
    output logic [rgbconv_pkg::PixW-1:0]    o_rgb
);
    import rgbconv_pkg::*;

    logic signed [AccW-1:0]  r_acc  [3];
    logic signed [ProdW-1:0] r_prod [3];

    // accumulate sums, then scale them in a separate cycle
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_ctl.clr) begin
                r_acc[c] <= '0;
            end else if (i_ctl.acc) begin
                r_acc[c] <= r_acc[c]
                    + AccW'($signed({1'b0, i_pix[8*c +: 8]}) * i_tap);
            end
            if (i_ctl.scale) begin
                r_prod[c] <= ProdW'(r_acc[c] * $signed({1'b0, i_scale}));
            end
        end
    end

    // round half up, clamp to 0..255
    always_comb begin
        logic signed [ProdW-1:0] v;
        logic [ProdW-17:0]       hi;
        for (int c = 0; c < 3; c++) begin
            v  = r_prod[c] + ProdW'(32768);
            hi = v[ProdW-1:16];
            if (v[ProdW-1]) begin
                o_rgb[8*c +: 8] = 8'd0;
            end else if (hi > (ProdW-16)'(255)) begin
                o_rgb[8*c +: 8] = 8'd255;
            end else begin
                o_rgb[8*c +: 8] = hi[7:0];
            end
        end
    end

endmodule

// ----- rtl/rgb_image_convolution.sv -----
// Top level: RGB 2-D convolution with line store and tap sequencer.
//
// Pixels enter in raster order on s_axis (tdata = red, green, blue from bit 0;
// tuser = flush flag). Filtered pixels leave on m_axis, tlast marking the last
// pixel of a frame. Configuration registers are written over the cfg channel,
// only while the block is idle; writing radius, width or height restarts the
// frame. Output pixel (r,c) appears once pixel R*width+R positions later has
// arrived; flush items at frame end drain the remaining rows.
// An item that yields no output leaves the sequencer idle. An item that yields
// an output takes one line store read per kernel tap through the single memory
// port, then accumulate drain, scale multiply and output load. s_axis_tready is
// high only while the sequencer is idle and no configuration write is offered.
// The output register holds one finished pixel, so the next item is accepted
// while it waits; if the receiver stalls, the next result waits in the
// sequencer until the register frees. Reset restores 3x3, 512x512, zero taps
// and scale 4096, and clears all position counters; the line store is not
// cleared, as every read is of a pixel written earlier in the frame.
module rgb_image_convolution #(
    parameter int MAX_WIDTH  = rgbconv_pkg::DefMaxWidth,
    parameter int MAX_HEIGHT = rgbconv_pkg::DefMaxHeight,
    parameter int MAX_KERNEL = rgbconv_pkg::DefMaxKernel
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rgbconv_pkg::PixW-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                          s_axis_tuser,   // is_flush
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rgbconv_pkg::PixW-1:0]  m_axis_tdata,   // red_out, green_out, blue_out
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  rgbconv_pkg::t_cfg_idx         i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);
    import rgbconv_pkg::*;

    localparam int LineRows = 2 * MAX_KERNEL;
    localparam int Depth    = LineRows * MAX_WIDTH;
    localparam int AW       = $clog2(Depth);
    localparam int SW       = $clog2(LineRows);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int EWW      = $clog2(MAX_WIDTH + 1);
    localparam int EWH      = $clog2(MAX_HEIGHT + 1);
    localparam int LW       = $clog2(2 * MAX_WIDTH + 4) + 1;
    localparam int XW       = CW + 2;
    localparam int YW       = RW + 2;
    localparam int LimRad   = (MAX_KERNEL - 1) / 2;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DRAIN, S_SCALE, S_OUT} t_state;

    t_state            r_state;
    logic [1:0]        r_rad_cfg;
    logic [DimW-1:0]   r_w, r_h;
    logic [CoefW-1:0]  r_coef;
    logic [ScaleW-1:0] r_scale;
    logic [CW-1:0]     r_in_col, r_out_col;
    logic [RW-1:0]     r_in_row, r_out_row;
    logic [SW-1:0]     r_in_slot, r_out_slot;
    logic [LW-1:0]     r_lead;
    logic              r_full;
    logic [2:0]        r_iy, r_ix;
    logic [4:0]        r_k;
    logic              r_pv;
    logic [4:0]        r_pt;
    logic              r_mvalid, r_mlast;
    logic [PixW-1:0]   r_mdata;

    logic [1:0]        rad;
    logic [2:0]        side_m1;
    logic [EWW-1:0]    w_eff;
    logic [EWH-1:0]    h_eff;
    logic [LW-1:0]     dly1, lead_nx;
    logic              in_fire, cfg_fire, pix, full_nx, fire;
    logic              in_last_col, in_last_row, out_last_col, out_last_row;
    logic signed [XW-1:0]   xs;
    logic signed [YW-1:0]   ys;
    logic signed [SW+1:0]   ss;
    logic [SW-1:0]     rd_slot;
    logic              inb;
    logic [AW-1:0]     mem_addr;
    logic [PixW-1:0]   mem_rdata, mac_rgb;
    t_mac_ctl          mac_ctl;
    logic signed [7:0] tap;

    // effective geometry
    always_comb begin
        rad = (r_rad_cfg >= 2'd2 && LimRad >= 2) ? 2'd2 : 2'd1;
        side_m1 = {rad, 1'b0};
        if (r_w == '0) begin
            w_eff = EWW'(1);
        end else if (int'(r_w) > MAX_WIDTH) begin
            w_eff = EWW'(MAX_WIDTH);
        end else begin
            w_eff = EWW'(r_w);
        end
        if (r_h == '0) begin
            h_eff = EWH'(1);
        end else if (int'(r_h) > MAX_HEIGHT) begin
            h_eff = EWH'(MAX_HEIGHT);
        end else begin
            h_eff = EWH'(r_h);
        end
        dly1 = (rad == 2'd2) ? (LW'(w_eff) << 1) + LW'(3) : LW'(w_eff) + LW'(2);
    end

    // input side bookkeeping; a configuration write takes precedence over input
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign pix      = in_fire && !s_axis_tuser && !r_full;
    assign in_last_col  = (EWW'(r_in_col) == w_eff - 1'b1);
    assign in_last_row  = (EWH'(r_in_row) == h_eff - 1'b1);
    assign out_last_col = (EWW'(r_out_col) == w_eff - 1'b1);
    assign out_last_row = (EWH'(r_out_row) == h_eff - 1'b1);
    assign full_nx  = r_full || (pix && in_last_col && in_last_row);
    assign lead_nx  = r_lead + LW'(pix);
    assign fire     = full_nx || (lead_nx >= dly1);

    // neighbor coordinates and line store slot
    always_comb begin
        xs = $signed({2'b00, r_out_col}) + $signed(XW'(r_ix)) - $signed(XW'(rad));
        ys = $signed({2'b00, r_out_row}) + $signed(YW'(r_iy)) - $signed(YW'(rad));
        ss = $signed({2'b00, r_out_slot}) + $signed((SW+2)'(r_iy))
             - $signed((SW+2)'(rad));
        if (ss < 0) begin
            ss = ss + (SW+2)'(LineRows);
        end else if (ss >= $signed((SW+2)'(LineRows))) begin
            ss = ss - (SW+2)'(LineRows);
        end
        rd_slot = SW'(ss);
        inb = !xs[XW-1] && !ys[YW-1]
              && (xs[XW-2:0] < w_eff) && (ys[YW-2:0] < h_eff);
        if (r_state == S_IDLE) begin
            mem_addr = AW'(32'(r_in_slot) * MAX_WIDTH + 32'(r_in_col));
        end else begin
            mem_addr = AW'(32'(rd_slot) * MAX_WIDTH + 32'(xs[XW-2:0]));
        end
    end

    rgbconv_linemem #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_linemem (
        .i_clk   (i_clk),
        .i_we    (pix),
        .i_addr  (mem_addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (mem_rdata)
    );

    // tap of the pixel whose read data arrives now
    assign tap = $signed(r_coef[{r_pt, 3'b000} +: 8]);

    always_comb begin
        mac_ctl.clr   = in_fire && fire;
        mac_ctl.acc   = r_pv;
        mac_ctl.scale = (r_state == S_SCALE);
    end

    rgbconv_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_pix   (mem_rdata),
        .i_tap   (tap),
        .i_scale (r_scale),
        .o_rgb   (mac_rgb)
    );

    // sequencer, counters, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rad_cfg  <= 2'd1;
            r_w        <= DimW'(512);
            r_h        <= DimW'(512);
            r_coef     <= '0;
            r_scale    <= ScaleW'(4096);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_lead     <= '0;
            r_full     <= 1'b0;
            r_iy       <= '0;
            r_ix       <= '0;
            r_k        <= '0;
            r_pv       <= 1'b0;
            r_pt       <= '0;
            r_mvalid   <= 1'b0;
            r_mlast    <= 1'b0;
        end else begin
            r_pv <= (r_state == S_READ) && inb;
            r_pt <= ((rad == 2'd2) ? 5'd24 : 5'd8) - r_k;
            // output state reloads the register itself
            if (m_axis_tready && r_state != S_OUT) begin
                r_mvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (pix) begin
                        if (in_last_col) begin
                            r_in_col <= '0;
                            if (in_last_row) begin
                                r_in_row  <= '0;
                                r_in_slot <= '0;
                            end else begin
                                r_in_row  <= r_in_row + 1'b1;
                                r_in_slot <= (r_in_slot == SW'(LineRows - 1)) ? '0
                                             : r_in_slot + 1'b1;
                            end
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                    end
                    if (in_fire) begin
                        r_full <= full_nx;
                        r_lead <= lead_nx;
                        if (fire) begin
                            r_state <= S_READ;
                            r_iy    <= '0;
                            r_ix    <= '0;
                            r_k     <= '0;
                        end
                    end
                end
                S_READ: begin
                    r_k <= r_k + 1'b1;
                    if (r_ix == side_m1) begin
                        r_ix <= '0;
                        r_iy <= r_iy + 1'b1;
                        if (r_iy == side_m1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_ix <= r_ix + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= mac_rgb;
                        r_mlast  <= out_last_col && out_last_row;
                        r_lead   <= r_lead - 1'b1;
                        r_state  <= S_IDLE;
                        if (out_last_col) begin
                            r_out_col <= '0;
                            if (out_last_row) begin
                                r_out_row  <= '0;
                                r_out_slot <= '0;
                                r_full     <= 1'b0;
                            end else begin
                                r_out_row  <= r_out_row + 1'b1;
                                r_out_slot <= (r_out_slot == SW'(LineRows - 1)) ? '0
                                              : r_out_slot + 1'b1;
                            end
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CfgRadius: r_rad_cfg <= i_cfg_data[1:0];
                    CfgWidth:  r_w       <= i_cfg_data[DimW-1:0];
                    CfgHeight: r_h       <= i_cfg_data[DimW-1:0];
                    CfgCoeffA: r_coef[63:0]    <= i_cfg_data;
                    CfgCoeffB: r_coef[127:64]  <= i_cfg_data;
                    CfgCoeffC: r_coef[191:128] <= i_cfg_data;
                    CfgCoeffL: r_coef[199:192] <= i_cfg_data[7:0];
                    CfgScale:  r_scale   <= i_cfg_data[ScaleW-1:0];
                    default: ;
                endcase
                if (i_cfg_index == CfgRadius || i_cfg_index == CfgWidth
                    || i_cfg_index == CfgHeight) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_slot  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                    r_lead     <= '0;
                    r_full     <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    // input lead over output never passes the raster delay
    a_lead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_full) |-> (r_lead < dly1))
        else $error("input lead exceeds raster delay");

    // output column stays inside the row
    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EWW'(r_out_col) < w_eff)
        else $error("output column out of range");

    // a new result is only loaded from the output state
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mvalid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");

endmodule
